@@ rtl/core/bmp_pixel_row_unpacker_top_assert.svh @@
// Assertion macros for the pixel row unpacker
`ifndef BMP_PIXEL_ROW_UNPACKER_TOP_ASSERT_SVH
`define BMP_PIXEL_ROW_UNPACKER_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BMPPRU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmppru assertion failed");

// next-cycle implication
`define BMPPRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bmppru assertion failed");

`endif

@@ rtl/core/bmppru_pkg.sv @@
package bmppru_pkg;

    localparam int WIDTH_BITS_DEF = 16;

    localparam int DEPTH_W = 2;
    localparam int ROW_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int GATH_W  = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEPTH_W-1:0] DEPTH_8  = 2'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_16 = 2'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_24 = 2'd2;
    localparam logic [DEPTH_W-1:0] DEPTH_32 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEPTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH = 8'd1;

    localparam logic [DEPTH_W-1:0] DEPTH_RST = DEPTH_24;
    localparam logic [ROW_W-1:0]   ROW_RST   = 16'd320;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [ROW_W-1:0]   row_width;
    } t_cfg;

endpackage

@@ rtl/core/bmppru_cfg.sv @@
module bmppru_cfg
    import bmppru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth     <= DEPTH_RST;
            r_cfg.row_width <= ROW_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_DEPTH: r_cfg.depth     <= i_cfg_data[DEPTH_W-1:0];
                CFG_IDX_WIDTH: r_cfg.row_width <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/core/bmppru_unpack.sv @@
module bmppru_unpack
    import bmppru_pkg::*;
#(
    parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_restart,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_pixel_word,
    output logic              o_row_end
);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_restart;

    // row and pixel state
    logic [WIDTH_BITS-1:0] r_col, n_col;
    logic [1:0]            r_bip, n_bip;
    logic [GATH_W-1:0]     r_gath, n_gath;
    logic [1:0]            r_pad, n_pad;

    // result register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word, n_out_word;
    logic              r_out_end, n_out_end;
    logic              n_emit;

    logic                      w_adv;
    logic                      w_proc;
    logic [WIDTH_BITS-1:0]     w_col;
    logic [1:0]                w_bip;
    logic [GATH_W-1:0]         w_gath;
    logic [1:0]                w_pad;
    logic [WIDTH_BITS-1:0]     w_next;
    logic [WIDTH_BITS+ROW_W-1:0] w_row_ext;
    logic                      w_last;
    logic [3:0]                w_prod;

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && !w_adv;
    assign w_proc  = r_in_valid && w_adv;

    assign w_row_ext = {{WIDTH_BITS{1'b0}}, i_cfg.row_width};
    assign w_prod    = {2'b00, i_cfg.row_width[1:0]} * ({2'b00, i_cfg.depth} + 4'd1);

    always_comb begin
        w_col  = r_in_restart ? '0 : r_col;
        w_bip  = r_in_restart ? '0 : r_bip;
        w_gath = r_in_restart ? '0 : r_gath;
        w_pad  = r_in_restart ? '0 : r_pad;

        w_next = w_col + {{(WIDTH_BITS-1){1'b0}}, 1'b1};
        w_last = (w_next == w_row_ext[WIDTH_BITS-1:0]);

        n_col      = w_col;
        n_bip      = w_bip;
        n_gath     = w_gath;
        n_pad      = w_pad;
        n_emit     = 1'b0;
        n_out_word = '0;
        n_out_end  = w_last;

        if (w_pad != 2'd0) begin
            n_pad = w_pad - 2'd1;
        end else if (w_bip < i_cfg.depth) begin
            n_gath = {w_gath[GATH_W-BYTE_W-1:0], r_in_byte};
            n_bip  = w_bip + 2'd1;
        end else begin
            n_emit = 1'b1;
            unique case (i_cfg.depth)
                DEPTH_8:  n_out_word = {16'd0, r_in_byte, 8'd0};
                DEPTH_16: n_out_word = {16'd0, r_in_byte, w_gath[7:0]};
                DEPTH_24: n_out_word = {8'd0, w_gath[15:0], r_in_byte};
                DEPTH_32: n_out_word = {w_gath, r_in_byte};
                default:  n_out_word = '0;
            endcase
            n_bip  = '0;
            n_gath = '0;
            if (w_last) begin
                n_col = '0;
                n_pad = 2'd0 - w_prod[1:0];
            end else begin
                n_col = w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_bip       <= '0;
            r_gath      <= '0;
            r_pad       <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= w_proc && n_emit;
            end
            if (w_proc) begin
                r_col  <= n_col;
                r_bip  <= n_bip;
                r_gath <= n_gath;
                r_pad  <= n_pad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte    <= i_data_byte;
            r_in_restart <= i_restart;
        end
        if (w_proc && n_emit) begin
            r_out_word <= n_out_word;
            r_out_end  <= n_out_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_word = r_out_word;
    assign o_row_end    = r_out_end;

endmodule

@@ rtl/core/bmp_pixel_row_unpacker_top.sv @@
// Pipeline: a byte goes through the input reg, then the result reg.
// Throughput: one byte per cycle when no held result stalls; a pixel word
//   each 1 to 4 bytes by depth, padding bytes taken at the same rate, dropped.
// Reset: synchronous, active low; depth 24 bpp, row width 320, row position,
//   partial pixel and pending padding cleared, both stages empty.
`include "bmp_pixel_row_unpacker_top_assert.svh"

module bmp_pixel_row_unpacker_top
    import bmppru_pkg::*;
#(
    parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_restart,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [WORD_W-1:0]     o_pixel_word,
    output logic                  o_row_end
);

    t_cfg w_cfg;

    bmppru_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bmppru_unpack #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_restart    (i_restart),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_word (o_pixel_word),
        .o_row_end    (o_row_end)
    );

    // back-pressure upstream only comes from a held result
    `BMPPRU_ASSERT_NOW(a_stall_src, o_stall, o_valid && i_stall)
    // after an idle cycle with nothing waiting, the input side is open
    `BMPPRU_ASSERT_NEXT(a_open, !i_valid && !o_valid, !o_stall)
    `BMPPRU_ASSERT_NOW(a_word8, o_valid && (w_cfg.depth == DEPTH_8),
        (o_pixel_word[7:0] == 8'd0) && (o_pixel_word[31:16] == 16'd0))
    `BMPPRU_ASSERT_NOW(a_word16, o_valid && (w_cfg.depth == DEPTH_16),
        o_pixel_word[31:16] == 16'd0)

endmodule
